>>> src/fspa_pkg.sv
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared types and constants of the fixed-size pool allocator: request and
// response layouts, operation and status codes, field widths.
// ----------------------------------------------------------------------------
package fspa_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OFFS_W   = 21;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned BUMP_W   = IDX_W + 1;
  localparam int unsigned LINK_W   = IDX_W + 1;

  // index space reachable with the index field
  localparam int unsigned INDEX_SPACE = 1 << IDX_W;

  // defaults
  localparam int unsigned POOL_ITEMS_DEF = 4096;
  localparam logic [SIZE_W-1:0] ITEM_BYTES_RST = SIZE_W'(8);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_REUSED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FRESH   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOPOOL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // request payload
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] item_index;
  } req_t;

  // response payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [OFFS_W-1:0]   byte_offset;
    logic [CNT_W-1:0]    reuse_count;
    logic [CNT_W-1:0]    fresh_count;
    logic [CNT_W-1:0]    release_count;
  } rsp_t;

endpackage

>>> src/fixed_size_pool_allocator_top.sv
// Timing: free, clear and fresh allocate requests respond in the cycle after
// acceptance; a free-list allocate reads the next list head from the link
// memory in S_POP, then registers its response. Throughput: 1 request per
// cycle while the output is not stalled; requests stall while in S_POP.
// Reset: list, bump pointer and counters clear, item size returns to 8;
// the link memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// fixed_size_pool_allocator_top
// Buffer index manager for equal-sized items: LIFO free list linked through
// a link memory, bump pointer for never-used items, running counters.
// ----------------------------------------------------------------------------
module fixed_size_pool_allocator_top
  import fspa_pkg::*;
#(
  parameter int unsigned POOL_ITEMS = POOL_ITEMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_req_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_rsp_o
);

  // link memory covers the indices that can actually be pushed
  localparam int unsigned LINK_DEPTH = (POOL_ITEMS < INDEX_SPACE) ? POOL_ITEMS : INDEX_SPACE;
  localparam int unsigned ADDR_W     = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam logic [BUMP_W-1:0] FRESH_LIMIT = BUMP_W'(LINK_DEPTH);
  localparam logic [16:0]       POOL_LIMIT  = 17'(POOL_ITEMS);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic                nonempty_q, nonempty_d;
  logic [BUMP_W-1:0]   bump_q, bump_d;
  logic [CNT_W-1:0]    reuse_q, reuse_d;
  logic [CNT_W-1:0]    fresh_q, fresh_d;
  logic [CNT_W-1:0]    release_q, release_d;
  logic [SIZE_W-1:0]   item_bytes_q;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_rsp_q, out_rsp_d;

  logic [LINK_W-1:0]   link_mem [LINK_DEPTH];
  logic [LINK_W-1:0]   rd_data_q;
  logic                mem_re;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [LINK_W-1:0]   mem_wdata;

  logic                accept;
  logic                load;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    grant;
  logic [IDX_W+SIZE_W-1:0] product;

  // accept only when idle and the output slot is empty or frees up this cycle
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // next state, list update and response
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    nonempty_d = nonempty_q;
    bump_d     = bump_q;
    reuse_d    = reuse_q;
    fresh_d    = fresh_q;
    release_d  = release_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = in_req_i.item_index[ADDR_W-1:0];
    mem_wdata  = {nonempty_q, head_q};
    load       = 1'b0;
    status     = ST_NOPOOL;
    grant      = '0;

    if (state_q == S_POP) begin
      grant      = head_q;
      head_d     = rd_data_q[IDX_W-1:0];
      nonempty_d = rd_data_q[IDX_W];
      reuse_d    = reuse_q + CNT_W'(1);
      status     = ST_REUSED;
      load       = 1'b1;
      state_d    = S_IDLE;
    end else if (accept) begin
      case (in_req_i.op)
        OP_ALLOC: begin
          if (nonempty_q) begin
            mem_re  = 1'b1;
            state_d = S_POP;
          end else if (bump_q < FRESH_LIMIT) begin
            grant   = bump_q[IDX_W-1:0];
            bump_d  = bump_q + BUMP_W'(1);
            fresh_d = fresh_q + CNT_W'(1);
            status  = ST_FRESH;
            load    = 1'b1;
          end else begin
            status = ST_NOPOOL;
            load   = 1'b1;
          end
        end
        OP_FREE: begin
          if ({5'd0, in_req_i.item_index} < POOL_LIMIT) begin
            mem_we     = 1'b1;
            head_d     = in_req_i.item_index;
            nonempty_d = 1'b1;
          end
          release_d = release_q + CNT_W'(1);
          status    = ST_FREED;
          load      = 1'b1;
        end
        OP_CLEAR: begin
          head_d     = '0;
          nonempty_d = 1'b0;
          bump_d     = '0;
          status     = ST_CLEARED;
          load       = 1'b1;
        end
        default: begin
          status = ST_NOPOOL;
          load   = 1'b1;
        end
      endcase
    end

    product = {{SIZE_W{1'b0}}, grant} * {{IDX_W{1'b0}}, item_bytes_q};

    // output slot: drained when taken, refilled on a new response
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    if (load) begin
      out_valid_d             = 1'b1;
      out_rsp_d.status        = status;
      out_rsp_d.granted_index = grant;
      out_rsp_d.byte_offset   = product[OFFS_W-1:0];
      out_rsp_d.reuse_count   = reuse_d;
      out_rsp_d.fresh_count   = fresh_d;
      out_rsp_d.release_count = release_d;
    end
  end

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      nonempty_q   <= 1'b0;
      bump_q       <= '0;
      reuse_q      <= '0;
      fresh_q      <= '0;
      release_q    <= '0;
      item_bytes_q <= ITEM_BYTES_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      bump_q      <= bump_d;
      reuse_q     <= reuse_d;
      fresh_q     <= fresh_d;
      release_q   <= release_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        item_bytes_q <= cfg_wdata_i;
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  // link memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= link_mem[head_q[ADDR_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> src/fspa_checker.sv
// ----------------------------------------------------------------------------
// fspa_checker
// Port-level checks of the pool allocator: response hold under stall, status
// range, zero grant fields on non-allocating responses, no overrun on stall.
// ----------------------------------------------------------------------------
module fspa_checker
  import fspa_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  // a stalled response stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped under stall");

  // a stalled response keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("response changed under stall");

  // status is one of the defined codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.status <= ST_CLEARED)
    else $error("undefined status code");

  // only a granted allocation carries an index and offset
  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_REUSED && out_rsp_o.status != ST_FRESH
    |-> out_rsp_o.granted_index == '0 && out_rsp_o.byte_offset == '0)
    else $error("grant fields set without a grant");

  // a request is never taken while a response is held back
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !(out_valid_o && out_stall_i))
    else $error("request accepted while response stalled");

endmodule

bind fixed_size_pool_allocator_top fspa_checker u_fspa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
